// File: hw/rtl/ebh_pkg.sv
// Shared types, codes and helpers of the estop button halt machine.
`default_nettype none

package ebh_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PpsW    = 10;
  localparam int unsigned HoldW   = 11;
  localparam int unsigned StateW  = 3;

  localparam logic [CfgIdxW-1:0] CFG_UNKILL_ALLOWED   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOGGLE_MODE      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_POLLS_PER_SECOND = 2'd2;

  localparam logic [PpsW-1:0] PPS_RESET = 10'd5;

  typedef enum logic [7:0] {
    ST_IDLE        = 8'b0000_0001,
    ST_KILL_DN     = 8'b0000_0010,
    ST_KILLED_DN   = 8'b0000_0100,
    ST_KILLED_UP   = 8'b0000_1000,
    ST_UNKILL_DN   = 8'b0001_0000,
    ST_UNKILL_TIME = 8'b0010_0000,
    ST_UNKILL_FIRE = 8'b0100_0000,
    ST_UNKILLED_DN = 8'b1000_0000
  } btn_state_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ALARM   = 2'd1,
    ACT_LATCHED = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef struct packed {
    logic            unkill_allowed;
    logic            toggle_mode;
    logic [PpsW-1:0] polls_per_second;
  } cfg_t;

  typedef struct packed {
    btn_state_e       btn;
    logic             still_latched;
    logic [HoldW-1:0] hold_ticks;
  } state_t;

  function automatic logic [StateW-1:0] encode_state(btn_state_e st);
    logic [StateW-1:0] code;
    code = 3'd0;
    case (st)
      ST_IDLE:        code = 3'd0;
      ST_KILL_DN:     code = 3'd1;
      ST_KILLED_DN:   code = 3'd2;
      ST_KILLED_UP:   code = 3'd3;
      ST_UNKILL_DN:   code = 3'd4;
      ST_UNKILL_TIME: code = 3'd5;
      ST_UNKILL_FIRE: code = 3'd6;
      ST_UNKILLED_DN: code = 3'd7;
      default:        code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ebh_cfg.sv
// Configuration registers of the estop button halt machine.
`default_nettype none

module ebh_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [ebh_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [ebh_pkg::PpsW-1:0]    wr_data_i,
  output ebh_pkg::cfg_t                    cfg_o
);

  ebh_pkg::cfg_t cfg_q;
  ebh_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        ebh_pkg::CFG_UNKILL_ALLOWED:   cfg_d.unkill_allowed   = wr_data_i[0];
        ebh_pkg::CFG_TOGGLE_MODE:      cfg_d.toggle_mode      = wr_data_i[0];
        ebh_pkg::CFG_POLLS_PER_SECOND: cfg_d.polls_per_second = wr_data_i;
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unkill_allowed   <= 1'b1;
      cfg_q.toggle_mode      <= 1'b0;
      cfg_q.polls_per_second <= ebh_pkg::PPS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/ebh_step.sv
// Next-state and action logic for one poll tick or idle check item.
`default_nettype none

module ebh_step (
  input  wire ebh_pkg::cfg_t   cfg_i,
  input  wire ebh_pkg::state_t state_i,
  input  wire logic            cmd_i,
  input  wire logic            released_i,
  input  wire logic            halted_i,
  output ebh_pkg::state_t      state_o,
  output ebh_pkg::action_e     action_o
);

  logic [ebh_pkg::HoldW-1:0] limit;
  logic [ebh_pkg::HoldW-1:0] hold_inc;
  logic                      pressed;

  assign limit    = {cfg_i.polls_per_second, 1'b0};
  assign hold_inc = state_i.hold_ticks + 11'd1;
  assign pressed  = !released_i;

  always_comb begin
    state_o  = state_i;
    action_o = ebh_pkg::ACT_NONE;
    if (cmd_i) begin
      case (state_i.btn)
        ebh_pkg::ST_KILL_DN: begin
          if (!halted_i) begin
            if (state_i.still_latched) begin
              action_o              = ebh_pkg::ACT_LATCHED;
              state_o.still_latched = 1'b0;
            end else begin
              action_o = ebh_pkg::ACT_ALARM;
            end
          end
        end
        ebh_pkg::ST_UNKILL_FIRE: begin
          if (halted_i) begin
            action_o = ebh_pkg::ACT_CLEAR;
          end
        end
        default: action_o = ebh_pkg::ACT_NONE;
      endcase
    end else begin
      case (state_i.btn)
        ebh_pkg::ST_IDLE: begin
          if (pressed) begin
            state_o.btn = ebh_pkg::ST_KILL_DN;
          end else if (cfg_i.unkill_allowed && !cfg_i.toggle_mode && halted_i) begin
            state_o.btn = ebh_pkg::ST_KILLED_UP;
          end
        end
        ebh_pkg::ST_KILL_DN: begin
          if (halted_i) begin
            state_o.btn = ebh_pkg::ST_KILLED_DN;
          end
        end
        ebh_pkg::ST_KILLED_DN: begin
          if (released_i) begin
            state_o.btn = ebh_pkg::ST_KILLED_UP;
          end else if (cfg_i.toggle_mode && !halted_i) begin
            state_o.btn           = ebh_pkg::ST_KILL_DN;
            state_o.still_latched = 1'b1;
          end
        end
        ebh_pkg::ST_KILLED_UP: begin
          if (!halted_i) begin
            state_o.btn = ebh_pkg::ST_IDLE;
          end
          if (cfg_i.unkill_allowed) begin
            if (cfg_i.toggle_mode) begin
              state_o.btn = ebh_pkg::ST_UNKILL_FIRE;
            end else if (pressed) begin
              state_o.btn = ebh_pkg::ST_UNKILL_DN;
            end
          end
        end
        ebh_pkg::ST_UNKILL_DN: begin
          state_o.hold_ticks = '0;
          state_o.btn        = ebh_pkg::ST_UNKILL_TIME;
        end
        ebh_pkg::ST_UNKILL_TIME: begin
          state_o.hold_ticks = hold_inc;
          if (hold_inc > limit) begin
            state_o.btn = ebh_pkg::ST_UNKILL_FIRE;
          end else if (released_i) begin
            state_o.hold_ticks = '0;
          end
          if (!halted_i) begin
            state_o.btn = ebh_pkg::ST_IDLE;
          end
        end
        ebh_pkg::ST_UNKILL_FIRE: begin
          if (!halted_i) begin
            state_o.btn = ebh_pkg::ST_UNKILLED_DN;
          end
        end
        ebh_pkg::ST_UNKILLED_DN: begin
          if (released_i) begin
            state_o.btn = ebh_pkg::ST_IDLE;
          end
        end
        default: state_o.btn = ebh_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/estop_button_halt_fsm.sv
// Top level of the estop button halt machine: item registers, state and checks.
`default_nettype none

// Emergency-stop button supervisor. Each input item is either a poll tick
// (tuser 0) that advances the button machine, or an idle check (tuser 1) that
// reports the halt action. Every item yields exactly one result item carrying
// the action and the machine state after the item. Throughput is one item per
// clock while m_axis_tready holds; an accepted item passes the input register,
// the single next-state stage and the result register on its way to a result.
// Configuration writes take effect in the next cycle and must be issued only
// while no item is in flight.
module estop_button_halt_fsm (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [0] button_released, [1] halted
  input  wire logic                        s_axis_tuser,  // [0] cmd
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [7:0]                  m_axis_tdata,  // [1:0] action, [4:2] fsm_state
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [ebh_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ebh_pkg::PpsW-1:0]    cfg_data_i
);

  ebh_pkg::cfg_t    cfg;
  ebh_pkg::state_t  state_q;
  ebh_pkg::state_t  state_d;
  ebh_pkg::action_e step_action;

  logic in_valid_q;
  logic in_cmd_q;
  logic in_released_q;
  logic in_halted_q;

  logic                       out_valid_q;
  logic                       out_valid_d;
  ebh_pkg::action_e           out_action_q;
  logic [ebh_pkg::StateW-1:0] out_fsm_q;

  logic out_free;
  logic fire;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  ebh_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  ebh_step u_step (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .cmd_i      (in_cmd_q),
    .released_i (in_released_q),
    .halted_i   (in_halted_q),
    .state_o    (state_d),
    .action_o   (step_action)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.btn           <= ebh_pkg::ST_IDLE;
      state_q.still_latched <= 1'b0;
      state_q.hold_ticks    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q      <= s_axis_tuser;
      in_released_q <= s_axis_tdata[0];
      in_halted_q   <= s_axis_tdata[1];
    end
    if (fire) begin
      out_action_q <= step_action;
      out_fsm_q    <= ebh_pkg::encode_state(state_d.btn);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_fsm_q, out_action_q};

  a_poll_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_cmd_q) |=> (out_action_q == ebh_pkg::ACT_NONE))
    else $error("poll tick produced a halt action");

  a_check_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_cmd_q) |=> (state_q.btn == $past(state_q.btn)))
    else $error("idle check changed the button state");

  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_fsm_q == ebh_pkg::encode_state(state_q.btn)))
    else $error("result state differs from machine state");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(state_q)))
    else $error("machine advanced while result was stalled");

endmodule

`default_nettype wire
